[rtl/amo_pkg.sv]
// Shared types and constants for the atomic memory operation unit.
// Used by amo_chk, amo_alu and amo_translate_check_alu; depends on nothing.
package amo_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISALIGN = 2'd1,
    ST_PGFAULT  = 2'd2,
    ST_ACCFAULT = 2'd3
  } status_t;

  localparam logic [3:0] OP_SWAP = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_AND  = 4'd2;
  localparam logic [3:0] OP_OR   = 4'd3;
  localparam logic [3:0] OP_XOR  = 4'd4;
  localparam logic [3:0] OP_MAX  = 4'd5;
  localparam logic [3:0] OP_MIN  = 4'd6;
  localparam logic [3:0] OP_MAXU = 4'd7;
  localparam logic [3:0] OP_MINU = 4'd8;

  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  localparam logic [1:0] LVL_4K = 2'd1;
  localparam logic [1:0] LVL_2M = 2'd2;
  localparam logic [1:0] LVL_1G = 2'd3;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CUR_PRIV = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MPRV     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MPP      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SUM      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRANS_EN = 3'd4;

  // Largest page offset (1 GiB page).
  localparam int unsigned OffW = 30;

  // Control that travels down the pipeline with each item.
  typedef struct packed {
    logic    valid;
    logic    fault;       // misaligned or page fault: address and data zeroed
    status_t fault_code;
    logic    load_ok;
    logic    store_ok;
  } ctl_t;

  // Current privilege state of the hart.
  typedef struct packed {
    logic [1:0] cur_priv;
    logic       mprv;
    logic [1:0] mpp;
    logic       sum;
    logic       trans_en;
  } csr_t;

endpackage

[rtl/amo_chk.sv]
// First pipeline stage: translation bypass decision, page crossing and
// permission checks, offset selection and sign extension. Depends on amo_pkg.
module amo_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  amo_pkg::csr_t               csr,
  input  logic [3:0]                  in_operation,
  input  logic [63:0]                 in_virt_addr,
  input  logic                        in_is_double,
  input  logic signed [63:0]          in_source_value,
  input  logic                        in_tlb_hit,
  input  logic [3:0]                  in_tlb_flags,
  input  logic [1:0]                  in_page_level,
  input  logic [63:0]                 in_page_base,
  input  logic [63:0]                 in_memory_data,
  input  logic                        in_load_ok,
  input  logic                        in_store_ok,
  output amo_pkg::ctl_t               s1_ctl,
  output logic [63:0]                 s1_addr_base,
  output logic [amo_pkg::OffW-1:0]    s1_addr_off,
  output logic [3:0]                  s1_op,
  output logic [63:0]                 s1_src,
  output logic [63:0]                 s1_old
);

  amo_pkg::ctl_t            ctl_r, ctl_nxt;
  logic [63:0]              base_r, base_nxt;
  logic [amo_pkg::OffW-1:0] off_r, off_nxt;
  logic [3:0]               op_r;
  logic [63:0]              src_r;
  logic [63:0]              old_r, old_nxt;

  logic       bypass;
  logic [1:0] eff_priv;
  logic       crossing;
  logic       pte_bad;
  logic       user_bad;
  logic       sum_bad;
  logic       lvl_bad;
  logic [amo_pkg::OffW-1:0] offset;

  always_comb begin
    bypass = ((csr.cur_priv == amo_pkg::PRIV_MACHINE) &&
              (!csr.mprv || (csr.mpp == amo_pkg::PRIV_MACHINE))) || !csr.trans_en;
    eff_priv = (csr.mprv && (csr.cur_priv == amo_pkg::PRIV_MACHINE)) ?
               csr.mpp : csr.cur_priv;
    // The access crosses a 4 KiB boundary when the in-page offset is too
    // close to the end of the page for its size.
    crossing = in_is_double ? (in_virt_addr[11:0] > 12'hFF8)
                            : (in_virt_addr[11:0] > 12'hFFC);
    pte_bad  = !in_tlb_hit || !in_tlb_flags[0] || !in_tlb_flags[1] || !in_tlb_flags[2];
    user_bad = (eff_priv == amo_pkg::PRIV_USER) && !in_tlb_flags[3];
    sum_bad  = !csr.sum && (eff_priv == amo_pkg::PRIV_SUPER) && in_tlb_flags[3];

    lvl_bad = 1'b0;
    offset  = '0;
    case (in_page_level)
      amo_pkg::LVL_4K: offset = {18'd0, in_virt_addr[11:0]};
      amo_pkg::LVL_2M: offset = {9'd0, in_virt_addr[20:0]};
      amo_pkg::LVL_1G: offset = in_virt_addr[amo_pkg::OffW-1:0];
      default:         lvl_bad = 1'b1;
    endcase

    ctl_nxt.valid      = in_fire;
    ctl_nxt.fault      = !bypass && (crossing || pte_bad || user_bad || sum_bad || lvl_bad);
    ctl_nxt.fault_code = crossing ? amo_pkg::ST_MISALIGN : amo_pkg::ST_PGFAULT;
    ctl_nxt.load_ok    = in_load_ok;
    ctl_nxt.store_ok   = in_store_ok;

    base_nxt = bypass ? in_virt_addr : in_page_base;
    off_nxt  = bypass ? '0 : offset;
    old_nxt  = in_is_double ? in_memory_data
                            : {{32{in_memory_data[31]}}, in_memory_data[31:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      base_r <= base_nxt;
      off_r  <= off_nxt;
      op_r   <= in_operation;
      src_r  <= in_source_value;
      old_r  <= old_nxt;
    end
  end

  assign s1_ctl       = ctl_r;
  assign s1_addr_base = base_r;
  assign s1_addr_off  = off_r;
  assign s1_op        = op_r;
  assign s1_src       = src_r;
  assign s1_old       = old_r;

endmodule

[rtl/amo_alu.sv]
// Second pipeline stage: physical address sum and the atomic operation on
// the old memory value. Depends on amo_pkg.
module amo_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  amo_pkg::ctl_t             s1_ctl,
  input  logic [63:0]               s1_addr_base,
  input  logic [amo_pkg::OffW-1:0]  s1_addr_off,
  input  logic [3:0]                s1_op,
  input  logic [63:0]               s1_src,
  input  logic [63:0]               s1_old,
  output amo_pkg::ctl_t             s2_ctl,
  output logic [63:0]               s2_pa,
  output logic [63:0]               s2_wdata,
  output logic [63:0]               s2_old
);

  amo_pkg::ctl_t ctl_r;
  logic [63:0]   pa_r, pa_nxt;
  logic [63:0]   wdata_r, wdata_nxt;
  logic [63:0]   old_r;

  logic lt_u;
  logic lt_s;
  logic gt_u;
  logic gt_s;

  always_comb begin
    pa_nxt = s1_addr_base + {{(64 - amo_pkg::OffW){1'b0}}, s1_addr_off};
    lt_u   = s1_src < s1_old;
    gt_u   = s1_src > s1_old;
    lt_s   = $signed(s1_src) < $signed(s1_old);
    gt_s   = $signed(s1_src) > $signed(s1_old);
    case (s1_op)
      amo_pkg::OP_SWAP: wdata_nxt = s1_src;
      amo_pkg::OP_ADD:  wdata_nxt = s1_src + s1_old;
      amo_pkg::OP_AND:  wdata_nxt = s1_src & s1_old;
      amo_pkg::OP_OR:   wdata_nxt = s1_src | s1_old;
      amo_pkg::OP_XOR:  wdata_nxt = s1_src ^ s1_old;
      amo_pkg::OP_MAX:  wdata_nxt = gt_s ? s1_src : s1_old;
      amo_pkg::OP_MIN:  wdata_nxt = lt_s ? s1_src : s1_old;
      amo_pkg::OP_MAXU: wdata_nxt = gt_u ? s1_src : s1_old;
      amo_pkg::OP_MINU: wdata_nxt = lt_u ? s1_src : s1_old;
      // Unknown codes write the old value back, leaving memory unchanged.
      default:          wdata_nxt = s1_old;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.valid) begin
      pa_r    <= pa_nxt;
      wdata_r <= wdata_nxt;
      old_r   <= s1_old;
    end
  end

  assign s2_ctl   = ctl_r;
  assign s2_pa    = pa_r;
  assign s2_wdata = wdata_r;
  assign s2_old   = old_r;

endmodule

[rtl/amo_translate_check_alu.sv]
// Top level of the atomic memory operation unit with Sv39 address checks.
// Instantiates amo_chk and amo_alu; depends on amo_pkg.
//
// Usage:
//   An item is taken at each rising edge with start high and busy low. The
//   unit is fully pipelined, so busy is always low and a new item may be
//   given in every cycle. Each item carries the virtual address, the TLB
//   lookup result for it, the old memory value and the memory status.
//   Each item passes the check, ALU and output registers in that order and
//   shows its result on the out_ ports, with out_valid high, for exactly
//   one cycle. Throughput is one item per cycle. The result cannot be held
//   off by the receiver; it must be taken in the cycle that out_valid
//   marks. Stages: privilege and permission checks with offset selection,
//   then the 64-bit physical address sum in parallel with the atomic ALU,
//   then the status priority and zeroing of fields for faulted items. The
//   privilege registers are written through cfg_we, cfg_index and cfg_data;
//   the user must do so only while no item is in flight, which the block
//   itself does not enforce. Reset restores machine mode with translation
//   off and empties the pipeline; no result is shown after a reset until a
//   new item is taken.
module amo_translate_check_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [amo_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [amo_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [3:0]                    in_operation,
  input  logic [63:0]                   in_virt_addr,
  input  logic                          in_is_double,
  input  logic signed [63:0]            in_source_value,
  input  logic                          in_tlb_hit,
  input  logic [3:0]                    in_tlb_flags,
  input  logic [1:0]                    in_page_level,
  input  logic [63:0]                   in_page_base,
  input  logic [63:0]                   in_memory_data,
  input  logic                          in_load_ok,
  input  logic                          in_store_ok,
  output logic                          out_valid,
  output logic [1:0]                    out_status_code,
  output logic [63:0]                   out_phys_addr,
  output logic [63:0]                   out_store_data,
  output logic                          out_store_enable,
  output logic signed [63:0]            out_old_value
);

  // Privilege state registers.
  amo_pkg::csr_t csr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr_r.cur_priv <= amo_pkg::PRIV_MACHINE;
      csr_r.mprv     <= 1'b0;
      csr_r.mpp      <= amo_pkg::PRIV_USER;
      csr_r.sum      <= 1'b0;
      csr_r.trans_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        amo_pkg::CFG_CUR_PRIV: csr_r.cur_priv <= cfg_data;
        amo_pkg::CFG_MPRV:     csr_r.mprv     <= cfg_data[0];
        amo_pkg::CFG_MPP:      csr_r.mpp      <= cfg_data;
        amo_pkg::CFG_SUM:      csr_r.sum      <= cfg_data[0];
        amo_pkg::CFG_TRANS_EN: csr_r.trans_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so every start is taken.
  logic in_fire;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  amo_pkg::ctl_t            s1_ctl;
  logic [63:0]              s1_addr_base;
  logic [amo_pkg::OffW-1:0] s1_addr_off;
  logic [3:0]               s1_op;
  logic [63:0]              s1_src;
  logic [63:0]              s1_old;

  amo_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .csr             (csr_r),
    .in_operation    (in_operation),
    .in_virt_addr    (in_virt_addr),
    .in_is_double    (in_is_double),
    .in_source_value (in_source_value),
    .in_tlb_hit      (in_tlb_hit),
    .in_tlb_flags    (in_tlb_flags),
    .in_page_level   (in_page_level),
    .in_page_base    (in_page_base),
    .in_memory_data  (in_memory_data),
    .in_load_ok      (in_load_ok),
    .in_store_ok     (in_store_ok),
    .s1_ctl          (s1_ctl),
    .s1_addr_base    (s1_addr_base),
    .s1_addr_off     (s1_addr_off),
    .s1_op           (s1_op),
    .s1_src          (s1_src),
    .s1_old          (s1_old)
  );

  amo_pkg::ctl_t s2_ctl;
  logic [63:0]   s2_pa;
  logic [63:0]   s2_wdata;
  logic [63:0]   s2_old;

  amo_alu u_alu (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_ctl       (s1_ctl),
    .s1_addr_base (s1_addr_base),
    .s1_addr_off  (s1_addr_off),
    .s1_op        (s1_op),
    .s1_src       (s1_src),
    .s1_old       (s1_old),
    .s2_ctl       (s2_ctl),
    .s2_pa        (s2_pa),
    .s2_wdata     (s2_wdata),
    .s2_old       (s2_old)
  );

  // Output stage: status priority and zeroing. A misaligned or page-faulting
  // item keeps only its fault code, all else zero; a failed load keeps only
  // the address; a failed store keeps the data but drops the store enable.
  logic              valid_r;
  amo_pkg::status_t  status_r, status_nxt;
  logic [63:0]       pa_r, pa_nxt;
  logic [63:0]       wdata_r, wdata_nxt;
  logic              sten_r, sten_nxt;
  logic [63:0]       old_r, old_nxt;
  logic              data_ok;

  always_comb begin
    data_ok   = !s2_ctl.fault && s2_ctl.load_ok;
    pa_nxt    = s2_ctl.fault ? 64'd0 : s2_pa;
    wdata_nxt = data_ok ? s2_wdata : 64'd0;
    old_nxt   = data_ok ? s2_old : 64'd0;
    sten_nxt  = data_ok && s2_ctl.store_ok;
    if (s2_ctl.fault) begin
      status_nxt = s2_ctl.fault_code;
    end else if (!s2_ctl.load_ok || !s2_ctl.store_ok) begin
      status_nxt = amo_pkg::ST_ACCFAULT;
    end else begin
      status_nxt = amo_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ctl.valid) begin
      status_r <= status_nxt;
      pa_r     <= pa_nxt;
      wdata_r  <= wdata_nxt;
      sten_r   <= sten_nxt;
      old_r    <= old_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_status_code  = status_r;
  assign out_phys_addr    = pa_r;
  assign out_store_data   = wdata_r;
  assign out_store_enable = sten_r;
  assign out_old_value    = old_r;

endmodule

[sim/amo_translate_check_alu_tb.sv]
// Self-checking testbench for amo_translate_check_alu: address checks, translation and AMO ALU.
// Drives items from a queue, predicts each result in the bench itself, checks every strobe.
// Depends on amo_pkg and the amo_translate_check_alu RTL.
module amo_translate_check_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Each result is taken once its item has passed the check, ALU and output registers.
  localparam int PIPE_LATENCY = 3;
  // Cycles without any accepted item or result before the run is declared hung.
  // The longest legal silence is a sender gap or a register update.
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 44;

  // TLB flag bit positions.
  localparam int FLAG_A = 0;
  localparam int FLAG_D = 1;
  localparam int FLAG_W = 2;
  localparam int FLAG_U = 3;

  // One atomic request as it is presented on the in_ ports.
  typedef struct {
    logic [3:0]  operation;
    logic [63:0] virt_addr;
    logic        is_double;
    logic [63:0] source_value;
    logic        tlb_hit;
    logic [3:0]  tlb_flags;
    logic [1:0]  page_level;
    logic [63:0] page_base;
    logic [63:0] memory_data;
    logic        load_ok;
    logic        store_ok;
  } amo_item_t;

  // The outcome of one request as it should appear on the out_ ports.
  typedef struct {
    amo_pkg::status_t status;
    logic [63:0]      phys_addr;
    logic [63:0]      store_data;
    logic             store_enable;
    logic [63:0]      old_value;
  } amo_result_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [amo_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [amo_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                         start     = 1'b0;
  logic                         busy;

  logic [3:0]          in_operation    = '0;
  logic [63:0]         in_virt_addr    = '0;
  logic                in_is_double    = 1'b0;
  logic signed [63:0]  in_source_value = '0;
  logic                in_tlb_hit      = 1'b0;
  logic [3:0]          in_tlb_flags    = '0;
  logic [1:0]          in_page_level   = '0;
  logic [63:0]         in_page_base    = '0;
  logic [63:0]         in_memory_data  = '0;
  logic                in_load_ok      = 1'b0;
  logic                in_store_ok     = 1'b0;

  logic                out_valid;
  logic [1:0]          out_status_code;
  logic [63:0]         out_phys_addr;
  logic [63:0]         out_store_data;
  logic                out_store_enable;
  logic signed [63:0]  out_old_value;

  // Bench copy of the privilege registers, starting at their reset values.
  logic [1:0] hart_priv  = amo_pkg::PRIV_MACHINE;
  logic       hart_mprv  = 1'b0;
  logic [1:0] hart_mpp   = amo_pkg::PRIV_USER;
  logic       hart_sum   = 1'b0;
  logic       hart_trans = 1'b0;

  amo_item_t   pending_items[$];
  amo_result_t expected_results[$];
  amo_item_t   drv_item;

  int gap_left    = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int mismatches  = 0;

  amo_translate_check_alu dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_virt_addr     (in_virt_addr),
    .in_is_double     (in_is_double),
    .in_source_value  (in_source_value),
    .in_tlb_hit       (in_tlb_hit),
    .in_tlb_flags     (in_tlb_flags),
    .in_page_level    (in_page_level),
    .in_page_base     (in_page_base),
    .in_memory_data   (in_memory_data),
    .in_load_ok       (in_load_ok),
    .in_store_ok      (in_store_ok),
    .out_valid        (out_valid),
    .out_status_code  (out_status_code),
    .out_phys_addr    (out_phys_addr),
    .out_store_data   (out_store_data),
    .out_store_enable (out_store_enable),
    .out_old_value    (out_old_value)
  );

  always #6 clk = ~clk;

  // Computes what the block must return for one request under the current
  // privilege registers. Misaligned and page faults zero every other field;
  // a failed load keeps only the address; a failed store keeps the data but
  // withholds the write.
  function automatic amo_result_t predict_amo(amo_item_t it);
    amo_result_t r;
    logic [63:0] last_byte;
    logic [63:0] off_mask;
    logic [63:0] old;
    logic [1:0]  eff_priv;
    logic        bypass;
    r.status       = amo_pkg::ST_OK;
    r.phys_addr    = '0;
    r.store_data   = '0;
    r.store_enable = 1'b0;
    r.old_value    = '0;
    // Machine mode bypasses unless MPRV points at a lower privilege; with
    // translation off every privilege uses the virtual address directly.
    bypass = (hart_priv == amo_pkg::PRIV_MACHINE &&
              (!hart_mprv || hart_mpp == amo_pkg::PRIV_MACHINE)) || !hart_trans;
    if (bypass) begin
      r.phys_addr = it.virt_addr;
    end else begin
      // The last byte address wraps at 2^64, so an access at the very top of
      // the address space counts as crossing into page zero.
      last_byte = it.virt_addr + (it.is_double ? 64'd7 : 64'd3);
      if (it.virt_addr[63:12] != last_byte[63:12]) begin
        r.status = amo_pkg::ST_MISALIGN;
        return r;
      end
      if (!it.tlb_hit || !it.tlb_flags[FLAG_A] || !it.tlb_flags[FLAG_D] ||
          !it.tlb_flags[FLAG_W]) begin
        r.status = amo_pkg::ST_PGFAULT;
        return r;
      end
      eff_priv = (hart_mprv && hart_priv == amo_pkg::PRIV_MACHINE) ? hart_mpp : hart_priv;
      // The reserved privilege falls through both checks like machine mode.
      if (eff_priv == amo_pkg::PRIV_USER && !it.tlb_flags[FLAG_U]) begin
        r.status = amo_pkg::ST_PGFAULT;
        return r;
      end
      if (!hart_sum && eff_priv == amo_pkg::PRIV_SUPER && it.tlb_flags[FLAG_U]) begin
        r.status = amo_pkg::ST_PGFAULT;
        return r;
      end
      case (it.page_level)
        amo_pkg::LVL_4K: off_mask = (64'd1 << 12) - 64'd1;
        amo_pkg::LVL_2M: off_mask = (64'd1 << 21) - 64'd1;
        amo_pkg::LVL_1G: off_mask = (64'd1 << 30) - 64'd1;
        default: begin
          r.status = amo_pkg::ST_PGFAULT;
          return r;
        end
      endcase
      r.phys_addr = it.page_base + (it.virt_addr & off_mask);
    end
    if (!it.load_ok) begin
      r.status = amo_pkg::ST_ACCFAULT;
      return r;
    end
    old = it.is_double ? it.memory_data : {{32{it.memory_data[31]}}, it.memory_data[31:0]};
    // The full 64-bit operand takes part even for word accesses.
    case (it.operation)
      amo_pkg::OP_SWAP: r.store_data = it.source_value;
      amo_pkg::OP_ADD:  r.store_data = it.source_value + old;
      amo_pkg::OP_AND:  r.store_data = it.source_value & old;
      amo_pkg::OP_OR:   r.store_data = it.source_value | old;
      amo_pkg::OP_XOR:  r.store_data = it.source_value ^ old;
      amo_pkg::OP_MAX:
        r.store_data = ($signed(it.source_value) > $signed(old)) ? it.source_value : old;
      amo_pkg::OP_MIN:
        r.store_data = ($signed(it.source_value) < $signed(old)) ? it.source_value : old;
      amo_pkg::OP_MAXU: r.store_data = (it.source_value > old) ? it.source_value : old;
      amo_pkg::OP_MINU: r.store_data = (it.source_value < old) ? it.source_value : old;
      default: r.store_data = old;  // undefined codes write memory back unchanged
    endcase
    r.old_value = old;
    if (!it.store_ok) begin
      r.status = amo_pkg::ST_ACCFAULT;
      return r;
    end
    r.store_enable = 1'b1;
    return r;
  endfunction

  // Random 64-bit words half of the time, else the sign and word boundaries that
  // matter for the signed compares and the word sign extension.
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 11))
      0:       return 64'h0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      3:       return 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return 64'h0000_0000_8000_0000;
      5:       return 64'hFFFF_FFFF_7FFF_FFFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A request that passes every check under a supervisor mapping.
  function automatic amo_item_t clean_item();
    amo_item_t it;
    it.operation    = amo_pkg::OP_SWAP;
    it.virt_addr    = 64'h0000_0040_1234_5678;
    it.is_double    = 1'b1;
    it.source_value = 64'h0123_4567_89AB_CDEF;
    it.tlb_hit      = 1'b1;
    it.tlb_flags    = 4'b0111;
    it.page_level   = amo_pkg::LVL_4K;
    it.page_base    = 64'h0000_0000_8000_0000;
    it.memory_data  = 64'hFEDC_BA98_7654_3210;
    it.load_ok      = 1'b1;
    it.store_ok     = 1'b1;
    return it;
  endfunction

  // Random request. Well-formed ones are mostly aligned, hit a valid,
  // writable mapping, load and store fine, so they reach the ALU; the
  // rest is pure noise over every field.
  function automatic amo_item_t make_item(bit well_formed);
    amo_item_t it;
    it.operation    = 4'($urandom_range(0, 15));
    it.virt_addr    = {$urandom, $urandom};
    it.is_double    = 1'($urandom);
    it.source_value = pick64();
    it.tlb_hit      = 1'($urandom);
    it.tlb_flags    = 4'($urandom);
    it.page_level   = 2'($urandom);
    it.page_base    = pick64();
    it.memory_data  = pick64();
    it.load_ok      = 1'($urandom);
    it.store_ok     = 1'($urandom);
    if (well_formed) begin
      if ($urandom_range(0, 9) != 0) it.operation = 4'($urandom_range(0, 8));
      if ($urandom_range(0, 7) == 0) begin
        // Last few bytes of a page: some of these cross into the next one.
        it.virt_addr[11:3] = '1;
      end else if (it.is_double) begin
        it.virt_addr[2:0] = 3'b000;
      end else begin
        it.virt_addr[1:0] = 2'b00;
      end
      it.tlb_hit = ($urandom_range(0, 19) != 0);
      if ($urandom_range(0, 9) != 0) it.tlb_flags[2:0] = 3'b111;
      it.page_level = ($urandom_range(0, 19) != 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      it.load_ok    = ($urandom_range(0, 15) != 0);
      it.store_ok   = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 4) == 0) it.source_value = it.memory_data;
    end
    return it;
  endfunction

  // Driver: presents the next queued item after a random gap. Bursts with
  // no gaps at all are mixed in so back-to-back items fill the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left  = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_results.push_back(predict_amo(drv_item));
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 39) == 0) begin
          burst_left = $urandom_range(10, 40);
        end
        if (burst_left > 0) begin
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 19))
            0, 1:            gap_left = $urandom_range(8, 40);
            2, 3, 4, 5, 6, 7, 8: gap_left = $urandom_range(1, 3);
            default:         gap_left = 0;
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drv_item         = pending_items.pop_front();
        in_operation    <= drv_item.operation;
        in_virt_addr    <= drv_item.virt_addr;
        in_is_double    <= drv_item.is_double;
        in_source_value <= drv_item.source_value;
        in_tlb_hit      <= drv_item.tlb_hit;
        in_tlb_flags    <= drv_item.tlb_flags;
        in_page_level   <= drv_item.page_level;
        in_page_base    <= drv_item.page_base;
        in_memory_data  <= drv_item.memory_data;
        in_load_ok      <= drv_item.load_ok;
        in_store_ok     <= drv_item.store_ok;
        start           <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding prediction.
  always @(posedge clk) begin
    amo_result_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status_code !== exp_res.status) begin
          $error("status_code: expected %0d, actual %0d", exp_res.status, out_status_code);
          mismatches++;
        end
        if (out_phys_addr !== exp_res.phys_addr) begin
          $error("phys_addr: expected %h, actual %h", exp_res.phys_addr, out_phys_addr);
          mismatches++;
        end
        if (out_store_data !== exp_res.store_data) begin
          $error("store_data: expected %h, actual %h", exp_res.store_data, out_store_data);
          mismatches++;
        end
        if (out_store_enable !== exp_res.store_enable) begin
          $error("store_enable: expected %0d, actual %0d", exp_res.store_enable,
                 out_store_enable);
          mismatches++;
        end
        if (out_old_value !== exp_res.old_value) begin
          $error("old_value: expected %h, actual %h", exp_res.old_value, out_old_value);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a long silence on both sides means the block has hung.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Returns once nothing is queued, on the ports or in flight. Sampling on
  // the falling edge keeps the check clear of the driver's rising-edge work.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || expected_results.size() != 0 || start) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [amo_pkg::CfgIdxW-1:0] idx,
                           input logic [amo_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    // One-bit registers keep only the low data bit.
    case (idx)
      amo_pkg::CFG_CUR_PRIV: hart_priv  = val;
      amo_pkg::CFG_MPRV:     hart_mprv  = val[0];
      amo_pkg::CFG_MPP:      hart_mpp   = val;
      amo_pkg::CFG_SUM:      hart_sum   = val[0];
      amo_pkg::CFG_TRANS_EN: hart_trans = val[0];
      default: ;
    endcase
  endtask

  // Registers change only once the pipeline has emptied.
  task automatic apply_config(input logic [1:0] priv, input logic [1:0] mprv,
                              input logic [1:0] mpp, input logic [1:0] sum,
                              input logic [1:0] trans);
    wait_idle();
    repeat (PIPE_LATENCY) @(posedge clk);
    write_reg(amo_pkg::CFG_CUR_PRIV, priv);
    write_reg(amo_pkg::CFG_MPRV, mprv);
    write_reg(amo_pkg::CFG_MPP, mpp);
    write_reg(amo_pkg::CFG_SUM, sum);
    write_reg(amo_pkg::CFG_TRANS_EN, trans);
  endtask

  // Queues a batch of random items, about one in seven of them noise.
  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      pending_items.push_back(make_item($urandom_range(0, 6) != 0));
    end
  endtask

  initial begin
    amo_item_t it;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state: machine mode, translation off, so addresses pass through.
    // Every operation sees a positive memory word against a negative operand,
    // which separates the signed and unsigned compares.
    for (int op = 0; op <= 8; op++) begin
      it              = clean_item();
      it.operation    = 4'(op);
      it.source_value = 64'h8000_0000_0000_0001;
      it.memory_data  = 64'h7FFF_FFFF_FFFF_FFFF;
      pending_items.push_back(it);
    end
    // Word access with a negative low word and garbage in the upper half.
    it              = clean_item();
    it.operation    = amo_pkg::OP_ADD;
    it.is_double    = 1'b0;
    it.source_value = '1;
    it.memory_data  = 64'hDEAD_BEEF_8000_0000;
    pending_items.push_back(it);
    // Undefined operation codes leave memory as it was.
    it           = clean_item();
    it.operation = 4'hF;
    pending_items.push_back(it);
    it           = clean_item();
    it.operation = 4'h9;
    it.is_double = 1'b0;
    pending_items.push_back(it);
    // A failed load, then a failed store.
    it         = clean_item();
    it.load_ok = 1'b0;
    pending_items.push_back(it);
    it          = clean_item();
    it.store_ok = 1'b0;
    it.operation = amo_pkg::OP_XOR;
    pending_items.push_back(it);
    // Top of the address space: no crossing check while bypassing.
    it           = clean_item();
    it.virt_addr = '1;
    pending_items.push_back(it);
    queue_random(PHASE_ITEMS);

    // Supervisor with translation on and SUM clear.
    apply_config(amo_pkg::PRIV_SUPER, 2'd0, amo_pkg::PRIV_USER, 2'd0, 2'd1);
    it           = clean_item();
    it.virt_addr = 64'h0000_0000_0001_0FFE;
    it.is_double = 1'b0;
    pending_items.push_back(it);
    // Crossing that only shows when the end address wraps past 2^64.
    it           = clean_item();
    it.virt_addr = 64'hFFFF_FFFF_FFFF_FFFC;
    pending_items.push_back(it);
    it         = clean_item();
    it.tlb_hit = 1'b0;
    pending_items.push_back(it);
    it           = clean_item();
    it.tlb_flags = 4'b0110;
    pending_items.push_back(it);
    it            = clean_item();
    it.page_level = 2'd0;
    pending_items.push_back(it);
    it           = clean_item();
    it.tlb_flags = 4'b1111;
    pending_items.push_back(it);
    it            = clean_item();
    it.page_level = amo_pkg::LVL_2M;
    it.virt_addr  = 64'hFFFF_FFFF_FFFF_FFF0;
    it.page_base  = '1;
    pending_items.push_back(it);
    it            = clean_item();
    it.page_level = amo_pkg::LVL_1G;
    it.virt_addr  = 64'h0000_0000_3FFF_FFF8;
    it.page_base  = 64'hFFFF_FFFF_C000_0010;
    pending_items.push_back(it);
    queue_random(PHASE_ITEMS);

    // User mode: a page without the user bit faults.
    apply_config(amo_pkg::PRIV_USER, 2'd0, amo_pkg::PRIV_USER, 2'd0, 2'd1);
    it = clean_item();
    pending_items.push_back(it);
    queue_random(PHASE_ITEMS);

    // Supervisor with SUM set. The sender is held back halfway until every
    // result is back, then the second half goes out into an empty pipeline.
    apply_config(amo_pkg::PRIV_SUPER, 2'd0, amo_pkg::PRIV_USER, 2'd1, 2'd1);
    queue_random(PHASE_ITEMS / 2);
    wait_idle();
    queue_random(PHASE_ITEMS / 2);

    // Machine mode with MPRV selecting user, supervisor and machine.
    apply_config(amo_pkg::PRIV_MACHINE, 2'd1, amo_pkg::PRIV_USER, 2'd0, 2'd1);
    queue_random(PHASE_ITEMS);
    apply_config(amo_pkg::PRIV_MACHINE, 2'd1, amo_pkg::PRIV_SUPER, 2'd1, 2'd1);
    queue_random(PHASE_ITEMS);
    apply_config(amo_pkg::PRIV_MACHINE, 2'd1, amo_pkg::PRIV_SUPER, 2'd0, 2'd1);
    queue_random(PHASE_ITEMS);
    apply_config(amo_pkg::PRIV_MACHINE, 2'd1, amo_pkg::PRIV_MACHINE, 2'd0, 2'd1);
    queue_random(PHASE_ITEMS);

    // The reserved privilege, directly and through MPP.
    apply_config(2'd2, 2'd0, amo_pkg::PRIV_USER, 2'd0, 2'd1);
    queue_random(PHASE_ITEMS);
    apply_config(amo_pkg::PRIV_MACHINE, 2'd1, 2'd2, 2'd1, 2'd1);
    queue_random(PHASE_ITEMS);

    // Translation off with a low privilege, MPRV set outside machine mode,
    // and plain machine mode with translation on.
    apply_config(amo_pkg::PRIV_SUPER, 2'd1, amo_pkg::PRIV_USER, 2'd0, 2'd0);
    queue_random(PHASE_ITEMS);
    apply_config(amo_pkg::PRIV_USER, 2'd1, amo_pkg::PRIV_MACHINE, 2'd0, 2'd1);
    queue_random(PHASE_ITEMS);
    apply_config(amo_pkg::PRIV_MACHINE, 2'd0, amo_pkg::PRIV_USER, 2'd0, 2'd1);
    queue_random(PHASE_ITEMS);

    // Random settings, with the unused upper data bit toggling on the
    // one-bit registers.
    for (int p = 0; p < 3; p++) begin
      apply_config(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
